[hw/rtl/slbfc_pkg.sv]
`default_nettype none

package slbfc_pkg;

    localparam int DATA_W     = 8;
    localparam int CMD_W      = 3;
    localparam int LEVEL_W    = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam int RX_DEPTH_DEF = 1024;
    localparam int TX_DEPTH_DEF = 1024;

    localparam logic [DATA_W-1:0]  XOFF_RST     = 8'd19;
    localparam logic               RAW_RST      = 1'b1;
    localparam logic               CLOCAL_RST   = 1'b0;
    localparam logic [LEVEL_W-1:0] IN_HIGH_RST  = 11'd768;
    localparam logic [LEVEL_W-1:0] IN_LOW_RST   = 11'd256;
    localparam logic [LEVEL_W-1:0] OUT_LOW_RST  = 11'd256;

    typedef enum logic [CMD_W-1:0] {
        CMD_RX_BYTE    = 3'd0,
        CMD_PUSH       = 3'd1,
        CMD_POP        = 3'd2,
        CMD_TX_READY   = 3'd3,
        CMD_MODEM      = 3'd4,
        CMD_CANCEL_IN  = 3'd5,
        CMD_CANCEL_OUT = 3'd6
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_XOFF_CHAR     = 3'd0,
        CFG_RAW_MODE      = 3'd1,
        CFG_CLOCAL        = 3'd2,
        CFG_IN_HIGH_WATER = 3'd3,
        CFG_IN_LOW_WATER  = 3'd4,
        CFG_OUT_LOW_WATER = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic               rx_valid;
        logic               tx_valid;
        logic               rts_level;
        logic               hangup;
        logic               notify;
        logic               dropped;
        logic               accepted;
        logic [LEVEL_W-1:0] in_level;
        logic [LEVEL_W-1:0] out_level;
        logic               out_done;
    } t_result;

endpackage

`default_nettype wire

[hw/rtl/serial_line_buffer_flow_control_unit.sv]
`default_nettype none

// Serial line receive and transmit rings with RTS/CTS and XOFF flow control. Each input word is
// one event (line byte, host push, host pop, transmitter ready, modem status, cancel of either
// ring) and gives exactly one result word. One word is accepted every cycle unless the result
// stage is full and cannot pass its word on. A result stage and an output register sit behind
// the update logic, so one more word is taken while a result waits on a stalled output; the
// registered read port of the ring memories loads with the result stage. Configuration is
// written through a plain write port and must only change while no word is in flight. Ring
// memories need no clearing after reset.
module serial_line_buffer_flow_control_unit
    import slbfc_pkg::*;
#(
    parameter int RX_DEPTH = RX_DEPTH_DEF,
    parameter int TX_DEPTH = TX_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,

    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [CMD_W-1:0]      i_command,
    input  wire logic [DATA_W-1:0]     i_data,
    input  wire logic                  i_line_idle,
    input  wire logic                  i_cts_in,
    input  wire logic                  i_dcd_in,
    input  wire logic                  i_dcd_delta,

    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [DATA_W-1:0]          o_rx_byte,
    output logic                       o_rx_valid,
    output logic [DATA_W-1:0]          o_tx_byte,
    output logic                       o_tx_valid,
    output logic                       o_rts_level,
    output logic                       o_hangup,
    output logic                       o_notify,
    output logic                       o_dropped,
    output logic                       o_accepted,
    output logic [LEVEL_W-1:0]         o_in_level,
    output logic [LEVEL_W-1:0]         o_out_level,
    output logic                       o_out_done
);

    localparam int RX_PW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int TX_PW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int RX_FW = $clog2(RX_DEPTH + 1);
    localparam int TX_FW = $clog2(TX_DEPTH + 1);
    localparam int RX_CW = (RX_FW > LEVEL_W) ? RX_FW : LEVEL_W;
    localparam int TX_CW = (TX_FW > LEVEL_W) ? TX_FW : LEVEL_W;

    // configuration
    logic [DATA_W-1:0]  r_xoff_char;
    logic               r_raw_mode;
    logic               r_clocal;
    logic [LEVEL_W-1:0] r_in_high_water;
    logic [LEVEL_W-1:0] r_in_low_water;
    logic [LEVEL_W-1:0] r_out_low_water;

    // ring and line state
    logic [RX_PW-1:0] r_rx_head, n_rx_head, r_rx_tail, n_rx_tail;
    logic [RX_FW-1:0] r_rx_fill, n_rx_fill;
    logic [TX_PW-1:0] r_tx_head, n_tx_head, r_tx_tail, n_tx_tail;
    logic [TX_FW-1:0] r_tx_fill, n_tx_fill;
    logic r_rts, n_rts, r_sw_ready, n_sw_ready, r_peer_ready, n_peer_ready;
    logic r_tx_queued, n_tx_queued, r_tx_done, n_tx_done, r_carrier_lost, n_carrier_lost;

    logic [DATA_W-1:0] r_rx_mem [RX_DEPTH];
    logic [DATA_W-1:0] r_tx_mem [TX_DEPTH];
    logic [DATA_W-1:0] r_rx_rd, r_tx_rd;

    // result stage and output register
    logic              r_s1_valid, r_o_valid;
    t_result           r_s1_res, r_o_res;
    logic              r_s1_byp;
    logic [DATA_W-1:0] r_s1_byp_data;
    logic [DATA_W-1:0] r_o_rx_byte, r_o_tx_byte;

    logic    accept, s1_move;
    t_result res;
    logic    rx_we, tx_we, tx_byp, send_ok, tx_queued_s, reported;
    logic [TX_FW-1:0] tx_fill_s, tx_fill_dec;
    logic [RX_FW-1:0] rx_fill_inc, rx_fill_dec;
    logic [RX_PW-1:0] rx_head_inc, rx_tail_inc;
    logic [TX_PW-1:0] tx_head_inc, tx_tail_inc;
    logic rx_full, tx_full;

    assign s1_move    = r_s1_valid && (!r_o_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_move;
    assign accept     = i_in_valid && o_in_ready;

    assign rx_full     = (r_rx_fill == RX_FW'(RX_DEPTH));
    assign tx_full     = (r_tx_fill == TX_FW'(TX_DEPTH));
    assign rx_fill_inc = r_rx_fill + RX_FW'(1);
    assign rx_fill_dec = r_rx_fill - RX_FW'(1);
    assign rx_head_inc = (r_rx_head == RX_PW'(RX_DEPTH - 1)) ? '0 : r_rx_head + RX_PW'(1);
    assign rx_tail_inc = (r_rx_tail == RX_PW'(RX_DEPTH - 1)) ? '0 : r_rx_tail + RX_PW'(1);
    assign tx_head_inc = (r_tx_head == TX_PW'(TX_DEPTH - 1)) ? '0 : r_tx_head + TX_PW'(1);
    assign tx_tail_inc = (r_tx_tail == TX_PW'(TX_DEPTH - 1)) ? '0 : r_tx_tail + TX_PW'(1);

    always_comb begin
        n_rx_head      = r_rx_head;
        n_rx_tail      = r_rx_tail;
        n_rx_fill      = r_rx_fill;
        n_tx_head      = r_tx_head;
        n_tx_tail      = r_tx_tail;
        n_tx_fill      = r_tx_fill;
        n_rts          = r_rts;
        n_sw_ready     = r_sw_ready;
        n_peer_ready   = r_peer_ready;
        n_tx_queued    = r_tx_queued;
        n_tx_done      = r_tx_done;
        n_carrier_lost = r_carrier_lost;
        res            = '0;
        rx_we          = 1'b0;
        tx_we          = 1'b0;
        tx_byp         = 1'b0;
        send_ok        = 1'b0;
        reported       = 1'b0;
        tx_fill_s      = r_tx_fill;
        tx_queued_s    = r_tx_queued;
        tx_fill_dec    = r_tx_fill - TX_FW'(1);

        case (i_command)
            CMD_RX_BYTE: begin
                if (!r_raw_mode) begin
                    n_sw_ready = (i_data != r_xoff_char);
                end
                if (rx_full) begin
                    res.dropped = 1'b1;
                end else begin
                    rx_we     = 1'b1;
                    n_rx_fill = rx_fill_inc;
                    n_rx_head = rx_head_inc;
                    if (RX_CW'(rx_fill_inc) == RX_CW'(r_in_high_water) && r_rts) begin
                        n_rts = 1'b0;
                    end
                    if (rx_fill_inc == RX_FW'(1)) begin
                        res.notify = 1'b1;
                    end
                end
            end
            CMD_PUSH: begin
                if (!tx_full) begin
                    tx_we        = 1'b1;
                    n_tx_head    = tx_head_inc;
                    tx_fill_s    = r_tx_fill + TX_FW'(1);
                    tx_queued_s  = 1'b1;
                    n_tx_fill    = tx_fill_s;
                    n_tx_queued  = 1'b1;
                    n_tx_done    = 1'b0;
                    res.accepted = 1'b1;
                    send_ok      = i_line_idle;
                    // empty ring: the word sent is the one being written
                    tx_byp       = (r_tx_fill == '0);
                end
            end
            CMD_POP: begin
                if (!r_clocal && r_carrier_lost) begin
                    n_carrier_lost = 1'b0;
                    reported       = 1'b1;
                end else if (r_rx_fill != '0) begin
                    res.rx_valid = 1'b1;
                    n_rx_tail    = rx_tail_inc;
                    n_rx_fill    = rx_fill_dec;
                    if (!r_rts && RX_CW'(rx_fill_dec) < RX_CW'(r_in_low_water)) begin
                        n_rts = 1'b1;
                    end
                end
            end
            CMD_TX_READY: begin
                send_ok = i_line_idle;
            end
            CMD_MODEM: begin
                if (!i_dcd_in && i_dcd_delta) begin
                    n_carrier_lost = 1'b1;
                    res.notify     = 1'b1;
                end
                n_peer_ready = i_cts_in | r_clocal;
            end
            CMD_CANCEL_IN: begin
                n_rx_fill = '0;
                n_rx_tail = r_rx_head;
                n_rts     = 1'b1;
            end
            CMD_CANCEL_OUT: begin
                n_tx_done   = 1'b0;
                n_tx_queued = 1'b0;
                n_tx_fill   = '0;
                n_tx_tail   = r_tx_head;
            end
            default: begin
            end
        endcase

        if (send_ok && (r_peer_ready || r_clocal) && tx_queued_s && r_sw_ready
                && tx_fill_s != '0) begin
            tx_fill_dec  = tx_fill_s - TX_FW'(1);
            res.tx_valid = 1'b1;
            n_tx_tail    = tx_tail_inc;
            n_tx_fill    = tx_fill_dec;
            if (tx_fill_dec == '0) begin
                n_tx_done   = 1'b1;
                n_tx_queued = 1'b0;
                res.notify  = 1'b1;
            end else if (TX_CW'(tx_fill_dec) == TX_CW'(r_out_low_water)) begin
                res.notify = 1'b1;
            end
        end

        res.rts_level = n_rts;
        res.hangup    = n_carrier_lost | reported;
        res.in_level  = LEVEL_W'(n_rx_fill);
        res.out_level = LEVEL_W'(n_tx_fill);
        res.out_done  = n_tx_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xoff_char     <= XOFF_RST;
            r_raw_mode      <= RAW_RST;
            r_clocal        <= CLOCAL_RST;
            r_in_high_water <= IN_HIGH_RST;
            r_in_low_water  <= IN_LOW_RST;
            r_out_low_water <= OUT_LOW_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_XOFF_CHAR:     r_xoff_char     <= i_cfg_data[DATA_W-1:0];
                CFG_RAW_MODE:      r_raw_mode      <= i_cfg_data[0];
                CFG_CLOCAL:        r_clocal        <= i_cfg_data[0];
                CFG_IN_HIGH_WATER: r_in_high_water <= i_cfg_data[LEVEL_W-1:0];
                CFG_IN_LOW_WATER:  r_in_low_water  <= i_cfg_data[LEVEL_W-1:0];
                CFG_OUT_LOW_WATER: r_out_low_water <= i_cfg_data[LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_head      <= '0;
            r_rx_tail      <= '0;
            r_rx_fill      <= '0;
            r_tx_head      <= '0;
            r_tx_tail      <= '0;
            r_tx_fill      <= '0;
            r_rts          <= 1'b1;
            r_sw_ready     <= 1'b1;
            r_peer_ready   <= CLOCAL_RST;
            r_tx_queued    <= 1'b0;
            r_tx_done      <= 1'b0;
            r_carrier_lost <= 1'b0;
        end else if (accept) begin
            r_rx_head      <= n_rx_head;
            r_rx_tail      <= n_rx_tail;
            r_rx_fill      <= n_rx_fill;
            r_tx_head      <= n_tx_head;
            r_tx_tail      <= n_tx_tail;
            r_tx_fill      <= n_tx_fill;
            r_rts          <= n_rts;
            r_sw_ready     <= n_sw_ready;
            r_peer_ready   <= n_peer_ready;
            r_tx_queued    <= n_tx_queued;
            r_tx_done      <= n_tx_done;
            r_carrier_lost <= n_carrier_lost;
        end
    end

    // ring memories, read data held with the result stage
    always_ff @(posedge i_clk) begin
        if (accept && rx_we) begin
            r_rx_mem[r_rx_head] <= i_data;
        end
        if (accept) begin
            r_rx_rd <= r_rx_mem[r_rx_tail];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && tx_we) begin
            r_tx_mem[r_tx_head] <= i_data;
        end
        if (accept) begin
            r_tx_rd <= r_tx_mem[r_tx_tail];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_res      <= res;
            r_s1_byp      <= tx_byp;
            r_s1_byp_data <= i_data;
        end
        if (s1_move) begin
            r_o_res     <= r_s1_res;
            r_o_rx_byte <= r_s1_res.rx_valid ? r_rx_rd : '0;
            r_o_tx_byte <= !r_s1_res.tx_valid ? '0 : (r_s1_byp ? r_s1_byp_data : r_tx_rd);
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_rx_byte   = r_o_rx_byte;
    assign o_rx_valid  = r_o_res.rx_valid;
    assign o_tx_byte   = r_o_tx_byte;
    assign o_tx_valid  = r_o_res.tx_valid;
    assign o_rts_level = r_o_res.rts_level;
    assign o_hangup    = r_o_res.hangup;
    assign o_notify    = r_o_res.notify;
    assign o_dropped   = r_o_res.dropped;
    assign o_accepted  = r_o_res.accepted;
    assign o_in_level  = r_o_res.in_level;
    assign o_out_level = r_o_res.out_level;
    assign o_out_done  = r_o_res.out_done;

    a_rx_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rx_fill == '0) |-> (r_rx_head == r_rx_tail))
        else $error("rx ring empty with pointers apart");

    a_tx_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tx_fill == '0) |-> (r_tx_head == r_tx_tail))
        else $error("tx ring empty with pointers apart");

    a_done_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_done |-> (r_tx_fill == '0))
        else $error("output done with words still queued");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_o_valid && !i_out_ready) |-> !o_in_ready)
        else $error("word accepted with both result stages full");

endmodule

`default_nettype wire
